[hdl/steering_distance_speed_limiter_top_assert.svh]
// assertion macros for the steering and distance speed limiter
// no dependencies; included by steering_distance_speed_limiter_top.sv
`ifndef STEERING_DISTANCE_SPEED_LIMITER_TOP_ASSERT_SVH
`define STEERING_DISTANCE_SPEED_LIMITER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define SDSL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sdsl assertion failed: same-cycle implication");

`define SDSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sdsl assertion failed: next-cycle implication");

`else

`define SDSL_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define SDSL_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[hdl/sdsl_pkg.sv]
`timescale 1ns / 1ps
// types and constants of the steering and distance speed limiter
// no dependencies; used by steering_distance_speed_limiter_top
package sdsl_pkg;

   localparam int unsigned ANGLE_W  = 12;
   localparam int unsigned DIST_W   = 13;
   localparam int unsigned PULSE_W  = 12;
   localparam int unsigned DZ_W     = 10;
   localparam int unsigned QUO_W    = 17;
   localparam int unsigned ROOT_W   = 9;
   localparam int unsigned SQ_W     = 18;
   localparam int unsigned SPROD_W  = 23;
   localparam int unsigned DPROD_W  = 25;
   localparam int unsigned DQ_W     = 12;
   localparam int unsigned CSR_AW   = 5;
   localparam int unsigned REQ_DW   = 32;
   localparam int unsigned RSP_DW   = 16;

   // pipeline stage map
   localparam int unsigned STG_PREP      = 0;
   localparam int unsigned STG_MUL       = 1;
   localparam int unsigned STG_DDIV_LAST = 13;
   localparam int unsigned STG_DFIN      = 14;
   localparam int unsigned STG_SDIV_LAST = 17;
   localparam int unsigned STG_SQ_FIRST  = 18;
   localparam int unsigned STG_SQ_LAST   = 26;
   localparam int unsigned STG_SMUL      = 27;
   localparam int unsigned STG_SFIN      = 28;
   localparam int unsigned STG_OUT       = 29;
   localparam int unsigned NUM_STAGES    = 30;

   typedef enum logic [2:0] {
      REG_LINK_ENABLE,
      REG_TOP_SPEED,
      REG_CORNER_SPEED,
      REG_STEER_DEADZONE,
      REG_STEER_MAX,
      REG_SLOW_THRESHOLD,
      REG_EMERGENCY_THRESHOLD,
      REG_RELIABLE_RANGE
   } reg_idx_type;

   typedef enum logic [1:0] {
      DIST_NONE,
      DIST_CORNER,
      DIST_INTERP
   } dist_mode_type;

   typedef struct packed {
      logic                       steer_on;
      logic                       span_empty;
      logic [DZ_W-1:0]            s_den;
      logic [DZ_W-1:0]            s_rem;
      logic [QUO_W-1:0]           s_quo;
      logic [SQ_W-1:0]            q_x;
      logic [SQ_W-1:0]            q_r;
      logic signed [SPROD_W-1:0]  s_prod;
      logic [PULSE_W-1:0]         from_steer;
      dist_mode_type              d_mode;
      logic [DIST_W-1:0]          d_num;
      logic [DIST_W-1:0]          d_den;
      logic [DIST_W-1:0]          d_rem;
      logic [DQ_W-1:0]            d_lo;
      logic                       d_neg;
      logic [PULSE_W-1:0]         from_dist;
      logic [PULSE_W-1:0]         pulse;
   } pipe_type;

endpackage

[hdl/steering_distance_speed_limiter_top.sv]
`timescale 1ns / 1ps
// steering and distance speed limiter, top level with csr block and pipeline
// depends on sdsl_pkg and steering_distance_speed_limiter_top_assert.svh
`include "steering_distance_speed_limiter_top_assert.svh"

// Takes one word per clock while req_tready is high (steer angle and front
// distance in req_tdata, the distance valid flag in req_tuser) and returns one
// ESC pulse word per input word, in order, from the last pipeline stage. The
// pipeline length is set by the 17-stage restoring divider for the steering
// ratio followed by the 9-stage square root, one bit per stage; the distance
// path (multiplier and 12-stage divider) runs beside them. The whole pipeline
// advances together: while the output word waits, req_tready is low. Registers
// are written through the csr port and must only change while no word is in flight.
module steering_distance_speed_limiter_top (
   input  logic                         clock,
   input  logic                         reset,
   // tdata: steer_angle [11:0], fwd_range [24:12], zero fill [31:25]
   input  logic [sdsl_pkg::REQ_DW-1:0]  req_tdata,
   // tuser: front_valid [0]
   input  logic                         req_tuser,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // tdata: speed_pulse [11:0], zero fill [15:12]
   output logic [sdsl_pkg::RSP_DW-1:0]  rsp_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [sdsl_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   localparam int unsigned N = sdsl_pkg::NUM_STAGES;

   // ---------------- configuration registers ----------------
   logic                          link_enable_ff;
   logic [sdsl_pkg::PULSE_W-1:0]  top_speed_ff;
   logic [sdsl_pkg::PULSE_W-1:0]  corner_speed_ff;
   logic [sdsl_pkg::DZ_W-1:0]     steer_deadzone_ff;
   logic [sdsl_pkg::DZ_W-1:0]     steer_max_ff;
   logic [sdsl_pkg::DIST_W-1:0]   slow_threshold_ff;
   logic [sdsl_pkg::DIST_W-1:0]   emergency_threshold_ff;
   logic [sdsl_pkg::DIST_W-1:0]   reliable_range_ff;

   logic                   csr_wr;
   sdsl_pkg::reg_idx_type  csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = sdsl_pkg::reg_idx_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         link_enable_ff         <= 1'b1;
         top_speed_ff           <= 12'd1600;
         corner_speed_ff        <= 12'd1550;
         steer_deadzone_ff      <= 10'd50;
         steer_max_ff           <= 10'd300;
         slow_threshold_ff      <= 13'd1000;
         emergency_threshold_ff <= 13'd300;
         reliable_range_ff      <= 13'd3000;
      end else if (csr_wr) begin
         unique case (csr_idx)
            sdsl_pkg::REG_LINK_ENABLE:         link_enable_ff <= csr_pwdata[0];
            sdsl_pkg::REG_TOP_SPEED:           top_speed_ff <= csr_pwdata[11:0];
            sdsl_pkg::REG_CORNER_SPEED:        corner_speed_ff <= csr_pwdata[11:0];
            sdsl_pkg::REG_STEER_DEADZONE:      steer_deadzone_ff <= csr_pwdata[9:0];
            sdsl_pkg::REG_STEER_MAX:           steer_max_ff <= csr_pwdata[9:0];
            sdsl_pkg::REG_SLOW_THRESHOLD:      slow_threshold_ff <= csr_pwdata[12:0];
            sdsl_pkg::REG_EMERGENCY_THRESHOLD: emergency_threshold_ff <= csr_pwdata[12:0];
            sdsl_pkg::REG_RELIABLE_RANGE:      reliable_range_ff <= csr_pwdata[12:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         sdsl_pkg::REG_LINK_ENABLE:         csr_prdata = {31'd0, link_enable_ff};
         sdsl_pkg::REG_TOP_SPEED:           csr_prdata = {20'd0, top_speed_ff};
         sdsl_pkg::REG_CORNER_SPEED:        csr_prdata = {20'd0, corner_speed_ff};
         sdsl_pkg::REG_STEER_DEADZONE:      csr_prdata = {22'd0, steer_deadzone_ff};
         sdsl_pkg::REG_STEER_MAX:           csr_prdata = {22'd0, steer_max_ff};
         sdsl_pkg::REG_SLOW_THRESHOLD:      csr_prdata = {19'd0, slow_threshold_ff};
         sdsl_pkg::REG_EMERGENCY_THRESHOLD: csr_prdata = {19'd0, emergency_threshold_ff};
         sdsl_pkg::REG_RELIABLE_RANGE:      csr_prdata = {19'd0, reliable_range_ff};
      endcase
   end

   // shared signed terms from the configuration
   logic signed [12:0] delta;
   logic signed [13:0] top_s;

   assign delta = $signed({1'b0, corner_speed_ff}) - $signed({1'b0, top_speed_ff});
   assign top_s = $signed({2'b00, top_speed_ff});

   // ---------------- pipeline ----------------
   logic [N-1:0]        vld_ff;
   logic [N-1:0]        vld_in;
   sdsl_pkg::pipe_type  pipe_ff [N];
   sdsl_pkg::pipe_type  pipe_in [N];
   sdsl_pkg::pipe_type  prep_in;
   logic                adv;

   assign adv        = !vld_ff[N-1] || rsp_tready;
   assign req_tready = adv;
   assign vld_in     = {vld_ff[N-2:0], req_tvalid};

   // input stage: magnitude, clamped excess, distance selection
   logic [11:0]                  ang;
   logic [11:0]                  mag;
   logic [11:0]                  excess;
   logic [sdsl_pkg::DZ_W-1:0]    span;
   logic [sdsl_pkg::DIST_W-1:0]  fwd_range;

   always_comb begin
      ang       = req_tdata[11:0];
      mag       = ang[11] ? (~ang + 12'd1) : ang;
      excess    = mag - {2'b00, steer_deadzone_ff};
      span      = steer_max_ff - steer_deadzone_ff;
      fwd_range = req_tuser ? req_tdata[24:12] : reliable_range_ff;

      prep_in            = '0;
      prep_in.steer_on   = mag > {2'b00, steer_deadzone_ff};
      prep_in.span_empty = steer_max_ff <= steer_deadzone_ff;
      prep_in.s_den      = span;
      prep_in.s_rem      = (excess > {2'b00, span}) ? span : excess[9:0];
      prep_in.d_num      = slow_threshold_ff - fwd_range;
      prep_in.d_den      = slow_threshold_ff - emergency_threshold_ff;
      if (fwd_range >= slow_threshold_ff) begin
         prep_in.d_mode = sdsl_pkg::DIST_NONE;
      end else if (fwd_range <= emergency_threshold_ff) begin
         prep_in.d_mode = sdsl_pkg::DIST_CORNER;
      end else begin
         prep_in.d_mode = sdsl_pkg::DIST_INTERP;
      end
   end

   // later stages, each one step of its unit
   always_comb begin
      logic [sdsl_pkg::DPROD_W-1:0]  dprod;
      logic [11:0]                   dmag;
      logic [10:0]                   st;
      logic                          sge;
      logic [sdsl_pkg::DIST_W:0]     dt;
      logic                          dge;
      logic [sdsl_pkg::SQ_W-1:0]     sq_bit;
      logic [sdsl_pkg::SQ_W-1:0]     sq_xi;
      logic [sdsl_pkg::SQ_W-1:0]     sq_ri;
      logic [sdsl_pkg::SQ_W-1:0]     sq_trial;
      logic [sdsl_pkg::ROOT_W:0]     root;
      logic signed [sdsl_pkg::SPROD_W-1:0] sadj;
      logic signed [sdsl_pkg::SPROD_W-1:0] sq8;
      logic signed [13:0]            dq;
      logic signed [13:0]            sum;

      pipe_in[sdsl_pkg::STG_PREP] = prep_in;

      for (int s = 1; s < N; s++) begin
         dprod    = '0;
         dmag     = '0;
         st       = '0;
         sge      = 1'b0;
         dt       = '0;
         dge      = 1'b0;
         sq_bit   = '0;
         sq_xi    = '0;
         sq_ri    = '0;
         sq_trial = '0;
         root     = '0;
         sadj     = '0;
         sq8      = '0;
         dq       = '0;
         sum      = '0;
         pipe_in[s] = pipe_ff[s-1];

         if (s == sdsl_pkg::STG_MUL) begin
            // steering quotient top bit; |delta| * num for the distance path
            sge = pipe_ff[s-1].s_rem >= pipe_ff[s-1].s_den;
            pipe_in[s].s_rem = sge ? (pipe_ff[s-1].s_rem - pipe_ff[s-1].s_den)
                                   : pipe_ff[s-1].s_rem;
            pipe_in[s].s_quo = {16'd0, sge};
            dmag  = delta[12] ? 12'(-delta) : 12'(delta);
            dprod = sdsl_pkg::DPROD_W'(dmag) * sdsl_pkg::DPROD_W'(pipe_ff[s-1].d_num);
            pipe_in[s].d_neg = delta[12];
            pipe_in[s].d_rem = dprod[24:12];
            pipe_in[s].d_lo  = dprod[11:0];
         end

         if (s > sdsl_pkg::STG_MUL && s <= sdsl_pkg::STG_SDIV_LAST) begin
            st  = {pipe_ff[s-1].s_rem, 1'b0};
            sge = st >= {1'b0, pipe_ff[s-1].s_den};
            pipe_in[s].s_rem = sge ? 10'(st - {1'b0, pipe_ff[s-1].s_den}) : st[9:0];
            pipe_in[s].s_quo = {pipe_ff[s-1].s_quo[15:0], sge};
         end

         if (s > sdsl_pkg::STG_MUL && s <= sdsl_pkg::STG_DDIV_LAST) begin
            // remainder and dividend low bits shift together, quotient enters at lsb
            dt  = {pipe_ff[s-1].d_rem, pipe_ff[s-1].d_lo[11]};
            dge = dt >= {1'b0, pipe_ff[s-1].d_den};
            pipe_in[s].d_rem = dge ? 13'(dt - {1'b0, pipe_ff[s-1].d_den}) : dt[12:0];
            pipe_in[s].d_lo  = {pipe_ff[s-1].d_lo[10:0], dge};
         end

         if (s == sdsl_pkg::STG_DFIN) begin
            dq  = $signed({2'b00, pipe_ff[s-1].d_lo});
            dq  = pipe_ff[s-1].d_neg ? -dq : dq;
            sum = top_s + dq;
            unique case (pipe_ff[s-1].d_mode)
               sdsl_pkg::DIST_CORNER: pipe_in[s].from_dist = corner_speed_ff;
               sdsl_pkg::DIST_INTERP: pipe_in[s].from_dist = sum[11:0];
               default:               pipe_in[s].from_dist = top_speed_ff;
            endcase
         end

         if (s >= sdsl_pkg::STG_SQ_FIRST && s <= sdsl_pkg::STG_SQ_LAST) begin
            sq_bit = sdsl_pkg::SQ_W'(32'd1 << (2 * (sdsl_pkg::STG_SQ_LAST - s)));
            if (s == sdsl_pkg::STG_SQ_FIRST) begin
               sq_xi = {1'b0, pipe_ff[s-1].s_quo};
               sq_ri = '0;
            end else begin
               sq_xi = pipe_ff[s-1].q_x;
               sq_ri = pipe_ff[s-1].q_r;
            end
            sq_trial = sq_ri + sq_bit;
            if (sq_xi >= sq_trial) begin
               pipe_in[s].q_x = sq_xi - sq_trial;
               pipe_in[s].q_r = (sq_ri >> 1) + sq_bit;
            end else begin
               pipe_in[s].q_x = sq_xi;
               pipe_in[s].q_r = sq_ri >> 1;
            end
         end

         if (s == sdsl_pkg::STG_SMUL) begin
            if (!pipe_ff[s-1].steer_on) begin
               root = '0;
            end else if (pipe_ff[s-1].span_empty) begin
               root = 10'd256;
            end else begin
               root = {1'b0, pipe_ff[s-1].q_r[8:0]};
            end
            pipe_in[s].s_prod = sdsl_pkg::SPROD_W'(delta) * sdsl_pkg::SPROD_W'($signed(root));
         end

         if (s == sdsl_pkg::STG_SFIN) begin
            // divide by 256 truncating toward zero
            sadj = pipe_ff[s-1].s_prod[sdsl_pkg::SPROD_W-1] ?
                   (pipe_ff[s-1].s_prod + 23'sd255) : pipe_ff[s-1].s_prod;
            sq8  = sadj >>> 8;
            sum  = top_s + sq8[13:0];
            pipe_in[s].from_steer = sum[11:0];
         end

         if (s == sdsl_pkg::STG_OUT) begin
            if (!link_enable_ff) begin
               pipe_in[s].pulse = top_speed_ff;
            end else if (pipe_ff[s-1].from_steer < pipe_ff[s-1].from_dist) begin
               pipe_in[s].pulse = pipe_ff[s-1].from_steer;
            end else begin
               pipe_in[s].pulse = pipe_ff[s-1].from_dist;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pipe_ff <= pipe_in;
      end
   end

   assign rsp_tvalid = vld_ff[N-1];
   assign rsp_tdata  = {4'd0, pipe_ff[N-1].pulse};

   // ---------------- checks ----------------
   // a stalled pipeline keeps every word where it is
   `SDSL_ASSERT_NEXT(a_stall_holds_valid, clock, reset, !adv, $stable(vld_ff))
   // a waiting result word blocks the input side
   `SDSL_ASSERT_IMPLY(a_stall_blocks_input, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
   // clamped ratio is at most one, so the root is at most 256
   `SDSL_ASSERT_IMPLY(a_root_range, clock, reset, vld_ff[sdsl_pkg::STG_SQ_LAST] && pipe_ff[sdsl_pkg::STG_SQ_LAST].steer_on && !pipe_ff[sdsl_pkg::STG_SQ_LAST].span_empty, pipe_ff[sdsl_pkg::STG_SQ_LAST].q_r <= 18'd256)
   // distance divider leaves a proper remainder
   `SDSL_ASSERT_IMPLY(a_dist_rem, clock, reset, vld_ff[sdsl_pkg::STG_DDIV_LAST] && pipe_ff[sdsl_pkg::STG_DDIV_LAST].d_mode == sdsl_pkg::DIST_INTERP, pipe_ff[sdsl_pkg::STG_DDIV_LAST].d_rem < pipe_ff[sdsl_pkg::STG_DDIV_LAST].d_den)

endmodule
